// ----- rtl/core/multisense_sequencer_averager_defines.svh -----
// Assertion helpers for the RTL
`ifndef MULTISENSE_SEQUENCER_AVERAGER_DEFINES_SVH
`define MULTISENSE_SEQUENCER_AVERAGER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define MSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/msa_pkg.sv -----
`default_nettype none

package msa_pkg;

  localparam int VAL_W          = 10;
  localparam int BUDGET_W       = 8;
  localparam int CFG_IDX_W      = 2;
  localparam int LANES          = 6;
  localparam int CURRENT_WINDOW = 8;
  localparam int VOLTAGE_WINDOW = 8;
  localparam int MAX_WINDOW     = (CURRENT_WINDOW > VOLTAGE_WINDOW) ?
                                  CURRENT_WINDOW : VOLTAGE_WINDOW;
  localparam int SUM_W          = VAL_W + $clog2(MAX_WINDOW + 1);

  localparam logic [BUDGET_W-1:0]  BUDGET_ALWAYS   = BUDGET_W'(255);
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_BUDGET = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_BUDGET = CFG_IDX_W'(1);

  typedef logic [VAL_W-1:0]    val_t;
  typedef logic [BUDGET_W-1:0] budget_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef sum_t [LANES-1:0]    sum_vec_t;

  typedef enum logic [1:0] {
    SEL_CUR0 = 2'd0,
    SEL_CUR1 = 2'd1,
    SEL_TEMP = 2'd2,
    SEL_VOLT = 2'd3
  } sel_t;

  // lanes 0..2 differences, 3..5 ground readings
  typedef struct packed {
    val_t [2:0] gnd;
    val_t [2:0] dif;
  } ring_item_t;

  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] idx;
    budget_t              data;
  } cfg_wr_t;

  typedef struct packed {
    sel_t cur;
    sel_t nxt;
  } seq_status_t;

  function automatic val_t item_lane(ring_item_t it, int unsigned k);
    val_t v;
    if (k < 3) begin
      v = it.dif[k];
    end else begin
      v = it.gnd[k - 3];
    end
    return v;
  endfunction

  function automatic budget_t budget_dec(budget_t b);
    budget_t r;
    if (b != '0 && b != BUDGET_ALWAYS) begin
      r = b - budget_t'(1);
    end else begin
      r = b;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/msa_cell.sv -----
`default_nettype none

module msa_cell
  import msa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       shift_en,
  input  wire ring_item_t d_in,
  output ring_item_t      d_out
);

  ring_item_t item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r <= '0;
    end else if (shift_en) begin
      item_r <= d_in;
    end
  end

  assign d_out = item_r;

endmodule

`default_nettype wire

// ----- rtl/core/msa_accum.sv -----
`default_nettype none

module msa_accum
  import msa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       en,
  input  wire ring_item_t add_in,
  input  wire ring_item_t drop_in,
  output sum_vec_t        sum_nxt
);

  sum_vec_t sum_r;

  always_comb begin
    for (int unsigned k = 0; k < LANES; k++) begin
      if (en) begin
        sum_nxt[k] = sum_r[k] - SUM_W'(item_lane(drop_in, k)) + SUM_W'(item_lane(add_in, k));
      end else begin
        sum_nxt[k] = sum_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/msa_seq.sv -----
`default_nettype none

module msa_seq
  import msa_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    step,
  input  wire cfg_wr_t cfg,
  output seq_status_t status
);

  sel_t    sel_r, sel_nxt;
  budget_t temp_rem_r, temp_rem_nxt;
  budget_t volt_rem_r, volt_rem_nxt;
  logic    take_temp, take_volt;

  // next state
  always_comb begin
    case (sel_r)
      SEL_CUR0: sel_nxt = SEL_CUR1;
      SEL_CUR1: begin
        if (temp_rem_r != '0) begin
          sel_nxt = SEL_TEMP;
        end else if (volt_rem_r != '0) begin
          sel_nxt = SEL_VOLT;
        end else begin
          sel_nxt = SEL_CUR0;
        end
      end
      SEL_TEMP: sel_nxt = (volt_rem_r != '0) ? SEL_VOLT : SEL_CUR0;
      SEL_VOLT: sel_nxt = SEL_CUR0;
      default:  sel_nxt = SEL_CUR0;
    endcase
  end

  // budget usage
  always_comb begin
    take_temp = 1'b0;
    take_volt = 1'b0;
    case (sel_r)
      SEL_CUR1: begin
        take_temp = (temp_rem_r != '0);
        take_volt = (temp_rem_r == '0) && (volt_rem_r != '0);
      end
      SEL_TEMP: take_volt = (volt_rem_r != '0);
      default: begin
        take_temp = 1'b0;
        take_volt = 1'b0;
      end
    endcase
  end

  always_comb begin
    temp_rem_nxt = temp_rem_r;
    volt_rem_nxt = volt_rem_r;
    if (cfg.en && cfg.idx == REG_TEMP_BUDGET) begin
      temp_rem_nxt = cfg.data;
    end else if (step && take_temp) begin
      temp_rem_nxt = budget_dec(temp_rem_r);
    end
    if (cfg.en && cfg.idx == REG_VOLT_BUDGET) begin
      volt_rem_nxt = cfg.data;
    end else if (step && take_volt) begin
      volt_rem_nxt = budget_dec(volt_rem_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r      <= SEL_CUR0;
      temp_rem_r <= '0;
      volt_rem_r <= '0;
    end else begin
      if (step) begin
        sel_r <= sel_nxt;
      end
      temp_rem_r <= temp_rem_nxt;
      volt_rem_r <= volt_rem_nxt;
    end
  end

  assign status.cur = sel_r;
  assign status.nxt = sel_nxt;

endmodule

`default_nettype wire

// ----- rtl/core/multisense_sequencer_averager.sv -----
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   in_master_ch0..2, in_slave_ch0..2
// out      output     out_valid / out_stall kind, next select, averages
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One transaction per cycle while in_stall is low; the output register
// holds each result from the cycle after its input is accepted. Averages come
// from running sums updated in the same cycle as their window cell chains shift.
// Synchronous active-low reset clears the window cells, sums and sequencer.
// in_stall follows out_stall only while the output register is full.
`default_nettype none
`include "multisense_sequencer_averager_defines.svh"

module multisense_sequencer_averager
  import msa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [VAL_W-1:0]     in_master_ch0,
  input  wire logic [VAL_W-1:0]     in_master_ch1,
  input  wire logic [VAL_W-1:0]     in_master_ch2,
  input  wire logic [VAL_W-1:0]     in_slave_ch0,
  input  wire logic [VAL_W-1:0]     in_slave_ch1,
  input  wire logic [VAL_W-1:0]     in_slave_ch2,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                out_sampled_kind,
  output logic [1:0]                out_next_select,
  output logic                      out_average_valid,
  output logic [VAL_W-1:0]          out_avg_ch0,
  output logic [VAL_W-1:0]          out_avg_ch1,
  output logic [VAL_W-1:0]          out_avg_ch2,
  output logic [VAL_W-1:0]          out_gnd_avg_ch0,
  output logic [VAL_W-1:0]          out_gnd_avg_ch1,
  output logic [VAL_W-1:0]          out_gnd_avg_ch2,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BUDGET_W-1:0]  cfg_data
);

  logic        in_fire;
  logic        out_valid_r;
  cfg_wr_t     cfg_wr;
  seq_status_t seq_st;
  ring_item_t  new_item;
  ring_item_t  cur_item;
  logic        cur_push, volt_push;
  ring_item_t  cur_q  [CURRENT_WINDOW];
  ring_item_t  volt_q [VOLTAGE_WINDOW];
  sum_vec_t    cur_sum_nxt, volt_sum_nxt;
  val_t        master [3];
  val_t        slave  [3];
  val_t [LANES-1:0] avg_nxt;
  logic        avg_valid_nxt;

  sel_t             kind_r, next_r;
  logic             avg_valid_r;
  val_t [LANES-1:0] avg_r;

  assign in_stall  = out_valid_r && out_stall;
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = '{en: cfg_valid, idx: cfg_index, data: cfg_data};

  msa_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (in_fire),
    .cfg    (cfg_wr),
    .status (seq_st)
  );

  assign master[0] = in_master_ch0;
  assign master[1] = in_master_ch1;
  assign master[2] = in_master_ch2;
  assign slave[0]  = in_slave_ch0;
  assign slave[1]  = in_slave_ch1;
  assign slave[2]  = in_slave_ch2;

  always_comb begin
    for (int unsigned k = 0; k < 3; k++) begin
      new_item.dif[k] = (master[k] > slave[k]) ? (master[k] - slave[k]) : '0;
      new_item.gnd[k] = slave[k];
    end
    cur_item     = new_item;
    cur_item.gnd = '0;
  end

  assign cur_push  = in_fire && (seq_st.cur == SEL_CUR0);
  assign volt_push = in_fire && (seq_st.cur == SEL_VOLT);

  for (genvar i = 0; i < CURRENT_WINDOW; i++) begin : g_cur
    if (i == 0) begin : g_head
      msa_cell u_cell (
        .clk (clk), .rst_n (rst_n), .shift_en (cur_push),
        .d_in (cur_item), .d_out (cur_q[i])
      );
    end else begin : g_body
      msa_cell u_cell (
        .clk (clk), .rst_n (rst_n), .shift_en (cur_push),
        .d_in (cur_q[i-1]), .d_out (cur_q[i])
      );
    end
  end

  for (genvar i = 0; i < VOLTAGE_WINDOW; i++) begin : g_volt
    if (i == 0) begin : g_head
      msa_cell u_cell (
        .clk (clk), .rst_n (rst_n), .shift_en (volt_push),
        .d_in (new_item), .d_out (volt_q[i])
      );
    end else begin : g_body
      msa_cell u_cell (
        .clk (clk), .rst_n (rst_n), .shift_en (volt_push),
        .d_in (volt_q[i-1]), .d_out (volt_q[i])
      );
    end
  end

  msa_accum u_cur_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (cur_push),
    .add_in  (cur_item),
    .drop_in (cur_q[CURRENT_WINDOW-1]),
    .sum_nxt (cur_sum_nxt)
  );

  msa_accum u_volt_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (volt_push),
    .add_in  (new_item),
    .drop_in (volt_q[VOLTAGE_WINDOW-1]),
    .sum_nxt (volt_sum_nxt)
  );

  always_comb begin
    avg_nxt       = '0;
    avg_valid_nxt = 1'b0;
    case (seq_st.cur)
      SEL_CUR0: begin
        avg_valid_nxt = 1'b1;
        for (int unsigned k = 0; k < 3; k++) begin
          avg_nxt[k] = VAL_W'(cur_sum_nxt[k] / SUM_W'(CURRENT_WINDOW));
        end
      end
      SEL_VOLT: begin
        avg_valid_nxt = 1'b1;
        for (int unsigned k = 0; k < LANES; k++) begin
          avg_nxt[k] = VAL_W'(volt_sum_nxt[k] / SUM_W'(VOLTAGE_WINDOW));
        end
      end
      default: begin
        avg_valid_nxt = 1'b0;
        avg_nxt       = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r      <= seq_st.cur;
      next_r      <= seq_st.nxt;
      avg_valid_r <= avg_valid_nxt;
      avg_r       <= avg_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sampled_kind  = kind_r;
  assign out_next_select   = next_r;
  assign out_average_valid = avg_valid_r;
  assign out_avg_ch0       = avg_r[0];
  assign out_avg_ch1       = avg_r[1];
  assign out_avg_ch2       = avg_r[2];
  assign out_gnd_avg_ch0   = avg_r[3];
  assign out_gnd_avg_ch1   = avg_r[4];
  assign out_gnd_avg_ch2   = avg_r[5];

  `MSA_ASSERT_NEXT(a_no_avg_on_idle_kinds,
    in_fire && (seq_st.cur == SEL_CUR1 || seq_st.cur == SEL_TEMP),
    out_valid && !out_average_valid, "average flagged for current1/temperature")
  `MSA_ASSERT_NOW(a_avg_kind,
    out_valid && out_average_valid,
    out_sampled_kind == SEL_CUR0 || out_sampled_kind == SEL_VOLT,
    "average valid on wrong kind")
  `MSA_ASSERT_NEXT(a_volt_returns,
    in_fire && seq_st.cur == SEL_VOLT,
    seq_st.cur == SEL_CUR0, "sequence did not return to current0 after voltage")
  `MSA_ASSERT_NEXT(a_next_tracks,
    in_fire, seq_st.cur == out_next_select, "reported next select differs from sequencer")

endmodule

`default_nettype wire
